>>> hdl/wwbe_pkg.sv
package wwbe_pkg;

    localparam int unsigned DataWidth = 32;
    localparam logic [15:0] MssReset = 16'd1460;
    localparam logic [15:0] MinWindowReset = 16'd50;
    localparam logic [31:0] InitialRttReset = 32'd20000;

    typedef enum logic [2:0] {
        OP_RTT   = 3'd0,
        OP_FAST  = 3'd1,
        OP_SLOW  = 3'd2,
        OP_LOSS  = 3'd3,
        OP_CWR   = 3'd4,
        OP_START = 3'd5,
        OP_RSVD6 = 3'd6,
        OP_RSVD7 = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_THRESH = 2'd1,
        ACT_WINDOW = 2'd2
    } act_t;

    typedef enum logic [1:0] {
        REG_MSS     = 2'd0,
        REG_MINWIN  = 2'd1,
        REG_INITRTT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] now;
        logic [31:0] ack_seq;
        logic [31:0] rtt_ticks;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] limit_window;
        logic [31:0] bandwidth_estimate;
        logic [31:0] min_rtt;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVENT,
        ST_SDIV,
        ST_FILTER,
        ST_PROD,
        ST_LSTART,
        ST_LDIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic event_step;
        logic sdiv_start;
        logic filter;
        logic prod;
        logic ldiv_start;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic close_due;
        logic div_busy;
    } sts_t;

endpackage

>>> hdl/wwbe_div.sv
module wwbe_div #(
    parameter int unsigned Width = wwbe_pkg::DataWidth
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [Width-1:0] dividend,
    input  logic [Width-1:0] divisor,
    output logic             busy,
    output logic [Width-1:0] quotient
);

    localparam int unsigned CntWidth = $clog2(Width + 1);

    logic [CntWidth-1:0] count_reg, count_next;
    logic [Width-1:0]    quo_reg, quo_next;
    logic [Width-1:0]    rem_reg, rem_next;
    logic [Width-1:0]    dsr_reg, dsr_next;
    logic [Width:0]      trial;

    assign trial = {rem_reg, quo_reg[Width-1]} - {1'b0, dsr_reg};

    always_comb
    begin
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        if (start)
        begin
            count_next = CntWidth'(Width);
            quo_next   = dividend;
            rem_next   = '0;
            dsr_next   = divisor;
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - 1'b1;
            if (!trial[Width])
            begin
                rem_next = trial[Width-1:0];
                quo_next = {quo_reg[Width-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[Width-2:0], quo_reg[Width-1]};
                quo_next = {quo_reg[Width-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = (count_reg != '0);
    assign quotient = quo_reg;

endmodule

>>> hdl/wwbe_datapath.sv
module wwbe_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  wwbe_pkg::cmd_t      cmd,
    output wwbe_pkg::sts_t      sts,
    input  wwbe_pkg::in_item_t  item_in,
    input  logic [15:0]         mss,
    input  logic [15:0]         min_window_ticks,
    input  logic [31:0]         initial_rtt_ticks,
    output wwbe_pkg::out_item_t item_out
);

    wwbe_pkg::in_item_t item_reg;
    logic [31:0] raw_reg, raw_next;
    logic [31:0] smooth_reg, smooth_next;
    logic [31:0] wstart_reg, wstart_next;
    logic [31:0] wbytes_reg, wbytes_next;
    logic [31:0] una_reg, una_next;
    logic [31:0] credit_reg, credit_next;
    logic [31:0] lrtt_reg, lrtt_next;
    logic [31:0] minrtt_reg, minrtt_next;
    logic        first_reg, first_next;
    logic        rearm_reg, rearm_next;
    logic [31:0] prod_reg;
    logic [1:0]  action_reg;
    logic [31:0] limit_reg;
    logic [31:0] bw_out_reg;
    logic [31:0] minrtt_out_reg;

    logic [31:0] elapsed, span, got, credit_tmp, una_eff, sample, raw_f, div_a, div_b;
    logic [31:0] div_q;
    logic        div_busy, div_start;

    assign elapsed = item_reg.now - wstart_reg;
    assign span = (lrtt_reg > {16'd0, min_window_ticks}) ? lrtt_reg
                                                          : {16'd0, min_window_ticks};
    assign sts.close_due = (lrtt_reg != '0) && (elapsed > span);
    assign sts.div_busy  = div_busy;
    assign sample = div_q;
    assign raw_f  = (raw_reg * 32'd7 + sample) >> 3;

    assign div_start = cmd.sdiv_start || cmd.ldiv_start;
    assign div_a = cmd.ldiv_start ? prod_reg : wbytes_reg;
    assign div_b = cmd.ldiv_start ? {16'd0, mss} : elapsed;

    wwbe_div #(.Width(wwbe_pkg::DataWidth)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .quotient (div_q)
    );

    always_comb
    begin
        raw_next    = raw_reg;
        smooth_next = smooth_reg;
        wstart_next = wstart_reg;
        wbytes_next = wbytes_reg;
        una_next    = una_reg;
        credit_next = credit_reg;
        lrtt_next   = lrtt_reg;
        minrtt_next = minrtt_reg;
        first_next  = first_reg;
        rearm_next  = rearm_reg;
        una_eff     = first_reg ? item_reg.ack_seq : una_reg;
        got         = item_reg.ack_seq - una_eff;
        credit_tmp  = credit_reg;
        if (cmd.event_step)
        begin
            unique case (wwbe_pkg::op_t'(item_reg.operation))
                wwbe_pkg::OP_RTT:
                begin
                    if (item_reg.rtt_ticks != '0)
                        lrtt_next = item_reg.rtt_ticks;
                end
                wwbe_pkg::OP_FAST, wwbe_pkg::OP_SLOW:
                begin
                    first_next = 1'b0;
                    if (item_reg.operation == wwbe_pkg::OP_SLOW)
                    begin
                        if (got == '0)
                        begin
                            credit_tmp = credit_reg + {16'd0, mss};
                            got = {16'd0, mss};
                        end
                        if (got > {16'd0, mss})
                        begin
                            if (credit_tmp >= got)
                            begin
                                credit_tmp = credit_tmp - got;
                                got = {16'd0, mss};
                            end
                            else
                            begin
                                got = got - credit_tmp;
                                credit_tmp = '0;
                            end
                        end
                        credit_next = credit_tmp;
                    end
                    una_next    = item_reg.ack_seq;
                    wbytes_next = (sts.close_due ? 32'd0 : wbytes_reg) + got;
                    if (sts.close_due)
                        wstart_next = item_reg.now;
                    if (rearm_reg || lrtt_reg < minrtt_reg)
                        minrtt_next = lrtt_reg;
                    rearm_next = 1'b0;
                end
                wwbe_pkg::OP_LOSS:
                    rearm_next = 1'b1;
                wwbe_pkg::OP_START:
                begin
                    raw_next    = '0;
                    smooth_next = '0;
                    wbytes_next = '0;
                    credit_next = '0;
                    rearm_next  = 1'b1;
                    lrtt_next   = initial_rtt_ticks;
                    minrtt_next = initial_rtt_ticks;
                    wstart_next = item_reg.now;
                    una_next    = item_reg.ack_seq;
                    first_next  = 1'b1;
                end
                default: ;
            endcase
        end
        if (cmd.filter)
        begin
            if (raw_reg == '0 && smooth_reg == '0)
            begin
                raw_next    = sample;
                smooth_next = sample;
            end
            else
            begin
                raw_next    = raw_f;
                smooth_next = (smooth_reg * 32'd7 + raw_f) >> 3;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg    <= '0;
            smooth_reg <= '0;
            wstart_reg <= '0;
            wbytes_reg <= '0;
            una_reg    <= '0;
            credit_reg <= '0;
            lrtt_reg   <= wwbe_pkg::InitialRttReset;
            minrtt_reg <= wwbe_pkg::InitialRttReset;
            first_reg  <= 1'b1;
            rearm_reg  <= 1'b1;
        end
        else
        begin
            raw_reg    <= raw_next;
            smooth_reg <= smooth_next;
            wstart_reg <= wstart_next;
            wbytes_reg <= wbytes_next;
            una_reg    <= una_next;
            credit_reg <= credit_next;
            lrtt_reg   <= lrtt_next;
            minrtt_reg <= minrtt_next;
            first_reg  <= first_next;
            rearm_reg  <= rearm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= item_in;
        if (cmd.prod)
            prod_reg <= 32'(64'(smooth_reg) * 64'(minrtt_reg));
        if (cmd.finish)
        begin
            unique case (wwbe_pkg::op_t'(item_reg.operation))
                wwbe_pkg::OP_LOSS: action_reg <= wwbe_pkg::ACT_THRESH;
                wwbe_pkg::OP_CWR:  action_reg <= wwbe_pkg::ACT_WINDOW;
                default:           action_reg <= wwbe_pkg::ACT_NONE;
            endcase
            if (mss == '0)
                limit_reg <= '1;
            else
                limit_reg <= (div_q > 32'd2) ? div_q : 32'd2;
            bw_out_reg     <= smooth_reg;
            minrtt_out_reg <= minrtt_reg;
        end
    end

    assign item_out.action             = action_reg;
    assign item_out.limit_window       = limit_reg;
    assign item_out.bandwidth_estimate = bw_out_reg;
    assign item_out.min_rtt            = minrtt_out_reg;

endmodule

>>> hdl/wwbe_ctrl.sv
module wwbe_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  logic [2:0]     operation,
    input  wwbe_pkg::sts_t sts,
    output wwbe_pkg::cmd_t cmd
);

    wwbe_pkg::state_t state_reg, state_next;
    logic             ovalid_reg, ovalid_next;
    logic             is_ack;

    assign is_ack = (operation == wwbe_pkg::OP_FAST) || (operation == wwbe_pkg::OP_SLOW);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wwbe_pkg::ST_IDLE:   if (in_valid) state_next = wwbe_pkg::ST_EVENT;
            wwbe_pkg::ST_EVENT:
            begin
                if (is_ack && sts.close_due)
                    state_next = wwbe_pkg::ST_SDIV;
                else
                    state_next = wwbe_pkg::ST_PROD;
            end
            wwbe_pkg::ST_SDIV:   if (!sts.div_busy) state_next = wwbe_pkg::ST_FILTER;
            wwbe_pkg::ST_FILTER: state_next = wwbe_pkg::ST_PROD;
            wwbe_pkg::ST_PROD:   state_next = wwbe_pkg::ST_LSTART;
            wwbe_pkg::ST_LSTART: state_next = wwbe_pkg::ST_LDIV;
            wwbe_pkg::ST_LDIV:   if (!sts.div_busy) state_next = wwbe_pkg::ST_DONE;
            wwbe_pkg::ST_DONE:
                if (!ovalid_reg || out_ready) state_next = wwbe_pkg::ST_IDLE;
            default:             state_next = wwbe_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            wwbe_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            wwbe_pkg::ST_EVENT:
            begin
                cmd.event_step = 1'b1;
                cmd.sdiv_start = is_ack && sts.close_due;
            end
            wwbe_pkg::ST_SDIV:   cmd.filter = !sts.div_busy;
            wwbe_pkg::ST_FILTER: ;
            wwbe_pkg::ST_PROD:   cmd.prod = 1'b1;
            wwbe_pkg::ST_LSTART: cmd.ldiv_start = 1'b1;
            wwbe_pkg::ST_LDIV:   ;
            wwbe_pkg::ST_DONE:   cmd.finish = !ovalid_reg || out_ready;
            default: ;
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (out_ready)
            ovalid_next = 1'b0;
        if (cmd.finish)
            ovalid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= wwbe_pkg::ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == wwbe_pkg::ST_IDLE)
        else $error("load outside idle");
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> ovalid_reg)
        else $error("finished item not presented");
    a_one_start: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.sdiv_start && cmd.ldiv_start))
        else $error("divider started twice");

endmodule

>>> hdl/westwood_bandwidth_estimator.sv
// From input acceptance an item passes the event step, then, if a window closes,
// the bandwidth division and the filter, then the product, the limit division
// and done; a window close runs two serial 32-step divisions, otherwise one.
// The next item is taken once the current one leaves the datapath, while its
// result waits in the output register. Reset (rst_n low, asynchronous) clears the
// estimator state, loads the register defaults and the initial rtt.
module westwood_bandwidth_estimator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  wwbe_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output wwbe_pkg::out_item_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [15:0] mss_reg;
    logic [15:0] minwin_reg;
    logic [31:0] initrtt_reg;
    logic [2:0]  op_reg;
    wwbe_pkg::cmd_t cmd;
    wwbe_pkg::sts_t sts;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mss_reg     <= wwbe_pkg::MssReset;
            minwin_reg  <= wwbe_pkg::MinWindowReset;
            initrtt_reg <= wwbe_pkg::InitialRttReset;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'd0 && paddr[3:2] != 2'd3)
        begin
            unique case (wwbe_pkg::reg_idx_t'(paddr[3:2]))
                wwbe_pkg::REG_MSS:     mss_reg     <= pwdata[15:0];
                wwbe_pkg::REG_MINWIN:  minwin_reg  <= pwdata[15:0];
                wwbe_pkg::REG_INITRTT: initrtt_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            wwbe_pkg::REG_MSS:     prdata = {16'd0, mss_reg};
            wwbe_pkg::REG_MINWIN:  prdata = {16'd0, minwin_reg};
            wwbe_pkg::REG_INITRTT: prdata = initrtt_reg;
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            op_reg <= in_data.operation;
    end

    wwbe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .operation (op_reg),
        .sts       (sts),
        .cmd       (cmd)
    );

    wwbe_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .item_in           (in_data),
        .mss               (mss_reg),
        .min_window_ticks  (minwin_reg),
        .initial_rtt_ticks (initrtt_reg),
        .item_out          (out_data)
    );

endmodule
